[rtl/core/psmt_pkg.sv]
// Shared types and opcodes for the pointer-size metadata table.
package psmt_pkg;

   typedef enum logic {
      PSMT_OP_SET    = 1'b0,
      PSMT_OP_LOOKUP = 1'b1
   } psmt_op_type;

   // Beat payload as it walks down the cell row.
   // size carries the new size on a set and the fetched size on a lookup.
   typedef struct packed {
      psmt_op_type opcode;
      logic        hit;
      logic        placed;
      logic [31:0] key;
      logic [31:0] size;
   } psmt_token_type;

endpackage

[rtl/core/psmt_cell.sv]
// One table entry cell: holds a key/size pair and passes the beat to the next cell.
module psmt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    tok_valid_in,
   input  psmt_pkg::psmt_token_type tok_in,
   output logic                    tok_valid_out,
   output psmt_pkg::psmt_token_type tok_out
);

   logic                     used_ff;
   logic                     used_in;
   logic [31:0]              key_ff;
   logic [31:0]              key_in;
   logic [31:0]              size_ff;
   logic [31:0]              size_in;
   logic                     tok_valid_ff;
   psmt_pkg::psmt_token_type tok_ff;
   psmt_pkg::psmt_token_type tok_in_next;
   logic                     is_set;
   logic                     match;
   logic                     claim;

   always_comb begin
      is_set = tok_valid_in && (tok_in.opcode == psmt_pkg::PSMT_OP_SET);
      match  = tok_valid_in && used_ff && (key_ff == tok_in.key);
      // occupied cells form a prefix, so the first free cell takes a new key
      claim  = is_set && !used_ff && !tok_in.hit && !tok_in.placed;

      tok_in_next        = tok_in;
      tok_in_next.hit    = tok_in.hit | match;
      tok_in_next.placed = tok_in.placed | claim;
      if (match && (tok_in.opcode == psmt_pkg::PSMT_OP_LOOKUP)) begin
         tok_in_next.size = size_ff;
      end

      used_in = used_ff | claim;
      key_in  = claim ? tok_in.key : key_ff;
      size_in = (claim || (match && is_set)) ? tok_in.size : size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else if (advance) begin
         used_ff      <= used_in;
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         key_ff  <= key_in;
         size_ff <= size_in;
         tok_ff  <= tok_in_next;
      end
   end

   assign tok_valid_out = tok_valid_ff;
   assign tok_out       = tok_ff;

endmodule

[rtl/core/pointer_size_metadata_table_core.sv]
// Top level of the pointer-size metadata table: a row of entry cells.
//
//   channel | dir | tdata                          | tuser
//   req_    | in  | key, entry_size                | opcode
//   rsp_    | out | size_out                       | found, table_full
//
// A beat crosses the cell row through each cell's token register in turn, one cell per cycle
// while the row advances; a new beat can enter every cycle unless the response is stalled.
// The last cell's token register is the response register.
// A stalled response freezes the whole row and deasserts req_tready.
// Reset empties the table.
module pointer_size_metadata_table_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] key, [63:32] entry_size
   input  logic [0:0]  req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] size_out
   output logic [1:0]  rsp_tuser    // [0] found, [1] table_full
);

   logic                     advance;
   logic                     tok_valid [0:TABLE_DEPTH];
   psmt_pkg::psmt_token_type tok       [0:TABLE_DEPTH];
   psmt_pkg::psmt_token_type last_tok;

   assign advance = !tok_valid[TABLE_DEPTH] || rsp_tready;

   always_comb begin
      tok_valid[0]      = req_tvalid;
      tok[0].opcode     = psmt_pkg::psmt_op_type'(req_tuser[0]);
      tok[0].hit        = 1'b0;
      tok[0].placed     = 1'b0;
      tok[0].key        = req_tdata[31:0];
      tok[0].size       = (req_tuser[0] == psmt_pkg::PSMT_OP_LOOKUP) ? 32'd0
                                                                     : req_tdata[63:32];
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      psmt_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .tok_valid_in  (tok_valid[i]),
         .tok_in        (tok[i]),
         .tok_valid_out (tok_valid[i+1]),
         .tok_out       (tok[i+1])
      );
   end

   assign last_tok   = tok[TABLE_DEPTH];
   assign req_tready = advance;
   assign rsp_tvalid = tok_valid[TABLE_DEPTH];

   always_comb begin
      rsp_tdata    = (last_tok.opcode == psmt_pkg::PSMT_OP_LOOKUP) ? last_tok.size : 32'd0;
      rsp_tuser[0] = last_tok.hit;
      rsp_tuser[1] = (last_tok.opcode == psmt_pkg::PSMT_OP_SET) && !last_tok.hit
                     && !last_tok.placed;
   end

endmodule

[rtl/core/psmt_checker.sv]
// Port-level checks for the pointer-size metadata table, bound to the top level.
module psmt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // a response stall blocks new requests
   a_stall_spread: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while response stalled");

   // a dropped set never reports a hit or a size
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && (rsp_tdata == 32'd0))
      else $error("table_full with found or nonzero size");

   // reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind pointer_size_metadata_table_core psmt_checker u_psmt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
